// ===== src/hashed_key_value_table_top_assert.svh =====
// Assertion macros used by the table's controller.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef HASHED_KEY_VALUE_TABLE_TOP_ASSERT_SVH
`define HASHED_KEY_VALUE_TABLE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HKV_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hkv assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HKV_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hkv assertion failed");

`endif

// ===== src/hkv_pkg.sv =====
`default_nettype none

package hkv_pkg;

    localparam logic [63:0] HashInit    = 64'd37;
    localparam logic [63:0] HashMul     = 64'd54059;
    localparam logic [63:0] HashCharMul = 64'd76963;
    localparam int          CountMax    = 63;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_ERASE  = 2'd1,
        CMD_LOOKUP = 2'd2,
        CMD_COUNT  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_EXISTING  = 2'd0,
        ST_ADDED     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;    // an input word is accepted this cycle
        logic clear;   // clearing sweep writes one hash entry
        logic scan;    // scan reads one hash entry
        logic fetch;   // read the value of the matched entry
        logic act;     // update the table and load the result
    } hkv_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sweep_last;  // the sweep counter points at the last entry
        logic read_busy;   // a hash read is still being compared
    } hkv_stat_t;

endpackage

`default_nettype wire

// ===== src/hkv_ctrl.sv =====
`default_nettype none

module hkv_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              key_last,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire hkv_pkg::hkv_stat_t stat,
    output hkv_pkg::hkv_cmd_t      ctl
);

    `include "hashed_key_value_table_top_assert.svh"

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_SCAN  = 6'b000100,
        S_DRAIN = 6'b001000,
        S_FETCH = 6'b010000,
        S_ACT   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                ctl.clear = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.take = 1'b1;
                    if (key_last)
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                ctl.scan = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FETCH;
            end
            S_FETCH:
            begin
                ctl.fetch  = 1'b1;
                state_next = S_ACT;
            end
            S_ACT:
            begin
                // Hold the command until the previous result has gone.
                if (!out_valid_reg || out_ready)
                begin
                    ctl.act    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.act)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `HKV_ASSERT_SAME(a_no_result_overwrite, ctl.act, !out_valid_reg || out_ready)
    `HKV_ASSERT_NEXT(a_busy_after_last, in_valid && in_ready && key_last, !in_ready)
    `HKV_ASSERT_NEXT(a_scan_to_drain, state_reg == S_SCAN && stat.sweep_last,
                     state_reg == S_DRAIN)
    `HKV_ASSERT_SAME(a_fetch_after_compare, ctl.fetch, !stat.read_busy)

endmodule

`default_nettype wire

// ===== src/hkv_datapath.sv =====
`default_nettype none

module hkv_datapath #(
    parameter int TABLE_DEPTH = 32,
    parameter int VALUE_BYTES = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire hkv_pkg::hkv_cmd_t ctl,
    output hkv_pkg::hkv_stat_t     stat,
    input  wire logic [1:0]        command,
    input  wire logic [7:0]        key_char,
    input  wire logic              key_last,
    input  wire logic [63:0]       value_word,
    output logic [1:0]             status,
    output logic [63:0]            found_value,
    output logic [5:0]             entry_count
);

    localparam int VALUE_W = 8 * VALUE_BYTES;
    localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam logic [IDX_W-1:0] LastIdx = IDX_W'(TABLE_DEPTH - 1);

    // Key hashing
    logic [63:0]          running_hash_reg;
    logic                 nonempty_reg;
    logic [63:0]          final_hash_reg;
    logic                 key_nonempty_reg;
    hkv_pkg::cmd_t        command_reg;
    logic [VALUE_W-1:0]   value_reg;
    logic [63:0]          mixed_hash;
    logic [63:0]          hash_next;
    logic                 char_seen;

    // Table storage
    logic [63:0]          hash_mem [TABLE_DEPTH];
    logic [VALUE_W-1:0]   value_mem [TABLE_DEPTH];
    logic [63:0]          rd_hash_reg;
    logic [VALUE_W-1:0]   rd_value_reg;

    // Scan tracking
    logic [IDX_W-1:0]     cnt_reg;
    logic                 rd_pending_reg;
    logic [IDX_W-1:0]     rd_idx_reg;
    logic                 match_hit_reg;
    logic [IDX_W-1:0]     match_idx_reg;
    logic                 free_hit_reg;
    logic [IDX_W-1:0]     free_idx_reg;
    logic                 match_ok;
    logic                 free_ok;

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;

    // Write ports
    logic                 hash_we;
    logic [IDX_W-1:0]     hash_waddr;
    logic [63:0]          hash_wdata;
    logic                 value_we;
    logic [IDX_W-1:0]     value_waddr;

    // Result
    hkv_pkg::status_t     status_reg;
    hkv_pkg::status_t     status_next;
    logic [63:0]          found_value_reg;
    logic [63:0]          found_value_next;
    logic [5:0]           entry_count_reg;
    logic [5:0]           entry_count_next;

    assign char_seen  = (key_char != 8'd0);
    assign mixed_hash = (running_hash_reg * hkv_pkg::HashMul)
                        ^ (64'(key_char) * hkv_pkg::HashCharMul);
    assign hash_next  = char_seen ? mixed_hash : running_hash_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_hash_reg <= hkv_pkg::HashInit;
            nonempty_reg     <= 1'b0;
        end
        else if (ctl.take)
        begin
            if (key_last)
            begin
                running_hash_reg <= hkv_pkg::HashInit;
                nonempty_reg     <= 1'b0;
            end
            else
            begin
                running_hash_reg <= hash_next;
                nonempty_reg     <= nonempty_reg | char_seen;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.take && key_last)
        begin
            final_hash_reg   <= hash_next;
            key_nonempty_reg <= nonempty_reg | char_seen;
            command_reg      <= hkv_pkg::cmd_t'(command);
            value_reg        <= value_word[VALUE_W-1:0];
        end
    end

    // An erase does not care whether the key was empty; insert and lookup do.
    assign match_ok = (rd_hash_reg == final_hash_reg) && (final_hash_reg != 64'd0)
                      && (key_nonempty_reg || command_reg == hkv_pkg::CMD_ERASE);
    assign free_ok  = (rd_hash_reg == 64'd0);

    assign stat.sweep_last = (cnt_reg == LastIdx);
    assign stat.read_busy  = rd_pending_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            rd_pending_reg <= 1'b0;
            rd_idx_reg     <= '0;
            match_hit_reg  <= 1'b0;
            match_idx_reg  <= '0;
            free_hit_reg   <= 1'b0;
            free_idx_reg   <= '0;
        end
        else
        begin
            if (ctl.clear || ctl.scan)
            begin
                cnt_reg <= (cnt_reg == LastIdx) ? '0 : cnt_reg + IDX_W'(1);
            end
            rd_pending_reg <= ctl.scan;
            rd_idx_reg     <= cnt_reg;
            if (ctl.take && key_last)
            begin
                match_hit_reg <= 1'b0;
                free_hit_reg  <= 1'b0;
            end
            else if (rd_pending_reg)
            begin
                if (!match_hit_reg && match_ok)
                begin
                    match_hit_reg <= 1'b1;
                    match_idx_reg <= rd_idx_reg;
                end
                if (!free_hit_reg && free_ok)
                begin
                    free_hit_reg <= 1'b1;
                    free_idx_reg <= rd_idx_reg;
                end
            end
        end
    end

    always_comb
    begin
        hash_we     = 1'b0;
        hash_waddr  = cnt_reg;
        hash_wdata  = 64'd0;
        value_we    = 1'b0;
        value_waddr = match_hit_reg ? match_idx_reg : free_idx_reg;
        count_next  = count_reg;
        status_next = hkv_pkg::ST_EXISTING;
        found_value_next = 64'd0;
        if (ctl.clear)
        begin
            hash_we = 1'b1;
        end
        case (command_reg)
            hkv_pkg::CMD_INSERT:
            begin
                if (match_hit_reg)
                begin
                    value_we    = ctl.act;
                    status_next = hkv_pkg::ST_EXISTING;
                end
                else if (free_hit_reg)
                begin
                    value_we    = ctl.act;
                    hash_we     = ctl.act;
                    hash_waddr  = free_idx_reg;
                    hash_wdata  = final_hash_reg;
                    status_next = hkv_pkg::ST_ADDED;
                    // A key hashing to zero leaves its entry free.
                    if (final_hash_reg != 64'd0)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    status_next = hkv_pkg::ST_FULL;
                end
            end
            hkv_pkg::CMD_ERASE:
            begin
                if (match_hit_reg)
                begin
                    hash_we     = ctl.act;
                    hash_waddr  = match_idx_reg;
                    hash_wdata  = 64'd0;
                    count_next  = count_reg - CNT_W'(1);
                    status_next = hkv_pkg::ST_EXISTING;
                end
                else
                begin
                    status_next = hkv_pkg::ST_NOT_FOUND;
                end
            end
            hkv_pkg::CMD_LOOKUP:
            begin
                if (match_hit_reg)
                begin
                    found_value_next = 64'(rd_value_reg);
                    status_next      = hkv_pkg::ST_EXISTING;
                end
                else
                begin
                    status_next = hkv_pkg::ST_NOT_FOUND;
                end
            end
            default:
            begin
                status_next = hkv_pkg::ST_EXISTING;
            end
        endcase
        if (32'(count_next) > hkv_pkg::CountMax)
        begin
            entry_count_next = 6'(hkv_pkg::CountMax);
        end
        else
        begin
            entry_count_next = 6'(count_next);
        end
    end

    always_ff @(posedge clk)
    begin
        if (hash_we)
        begin
            hash_mem[hash_waddr] <= hash_wdata;
        end
        if (ctl.scan)
        begin
            rd_hash_reg <= hash_mem[cnt_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (value_we)
        begin
            value_mem[value_waddr] <= value_reg;
        end
        if (ctl.fetch)
        begin
            rd_value_reg <= value_mem[match_idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (ctl.act)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.act)
        begin
            status_reg      <= status_next;
            found_value_reg <= found_value_next;
            entry_count_reg <= entry_count_next;
        end
    end

    assign status      = status_reg;
    assign found_value = found_value_reg;
    assign entry_count = entry_count_reg;

endmodule

`default_nettype wire

// ===== src/hashed_key_value_table_top.sv =====
// A word without key_last goes into the running hash and the input stays ready;
// one with key_last starts the scan, and drain, fetch and act then load the result.
// Input: after it no word is taken until act, which waits for the earlier result to
// go; the scan reads one stored hash per cycle from the hash memory.
// Reset: the running hash returns to 37 and a clearing pass writing each entry once
// frees every entry; no word is accepted until it has finished.
`default_nettype none

module hashed_key_value_table_top #(
    parameter int TABLE_DEPTH = 32,
    parameter int VALUE_BYTES = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  command,
    input  wire logic [7:0]  key_char,
    input  wire logic        key_last,
    input  wire logic [63:0] value_word,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [63:0]      found_value,
    output logic [5:0]       entry_count
);

    hkv_pkg::hkv_cmd_t  ctl;
    hkv_pkg::hkv_stat_t stat;

    hkv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .key_last  (key_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    hkv_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_BYTES (VALUE_BYTES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .stat        (stat),
        .command     (command),
        .key_char    (key_char),
        .key_last    (key_last),
        .value_word  (value_word),
        .status      (status),
        .found_value (found_value),
        .entry_count (entry_count)
    );

endmodule

`default_nettype wire
